>>> rtl/dmac_pkg.sv
// Shared types, address constants and decode codes for the DMA controller register file.
`timescale 1ns / 1ps
`default_nettype none

package dmac_pkg;

  localparam int CHANNEL_COUNT    = 7;
  localparam int TABLE_CHANNEL_ID = 6;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = 1;

  localparam logic [31:0] CHAN_BASE_ADDR = 32'h1f80_1080;
  localparam logic [31:0] DPCR_ADDR      = 32'h1f80_10f0;
  localparam logic [31:0] DICR_ADDR      = 32'h1f80_10f4;
  localparam logic [31:0] UNK1_ADDR      = 32'h1f80_10f8;
  localparam logic [31:0] UNK2_ADDR      = 32'h1f80_10fc;
  localparam logic [31:0] UNK1_VALUE     = 32'h7fe3_58d1;
  localparam logic [31:0] UNK2_VALUE     = 32'h00ff_fff7;

  // Bus command codes.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_DONE  = 2'd2;

  // Access size codes.
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // Operation kinds after classification.
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_DONE  = 2'd3;

  // Register targets after address decode.
  localparam logic [3:0] TGT_NONE    = 4'd0;
  localparam logic [3:0] TGT_DPCR    = 4'd1;
  localparam logic [3:0] TGT_DICR    = 4'd2;
  localparam logic [3:0] TGT_UNK1    = 4'd3;
  localparam logic [3:0] TGT_UNK2    = 4'd4;
  localparam logic [3:0] TGT_MADR    = 4'd5;
  localparam logic [3:0] TGT_BCR     = 4'd6;
  localparam logic [3:0] TGT_CHCR    = 4'd7;
  localparam logic [3:0] TGT_BCR_SUB = 4'd8;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  target;
    logic [2:0]  chan;
    logic [1:0]  rshift;
    logic        sub_half;
    logic [1:0]  sub_sel;
    logic [31:0] wdata;
    logic [2:0]  done_chan;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/dmac_front.sv
// Front end: accepts bus transactions and decodes them into register operations.
`timescale 1ns / 1ps
`default_nettype none

module dmac_front
  import dmac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] address,
  input  wire logic [1:0]  access_size,
  input  wire logic [31:0] write_data,
  input  wire logic [2:0]  done_channel,
  input  wire logic        q_full,
  output logic             push,
  output item_t            push_item
);

  logic  front_valid;
  item_t front_item;
  item_t dec;
  logic  accept;
  logic  chan_ok;
  logic  aligned;
  logic [3:0] glob_tgt;
  logic [3:0] chan_tgt;

  assign push      = front_valid && !q_full;
  assign in_stall  = front_valid && q_full;
  assign accept    = in_valid && !in_stall;
  assign push_item = front_item;

  always_comb begin
    chan_ok = (address[28:7] == CHAN_BASE_ADDR[28:7]) &&
              (address[6:4] < 3'(CHANNEL_COUNT));
    aligned = (address[1:0] == 2'b00);

    if (address[28:2] == DPCR_ADDR[28:2]) begin
      glob_tgt = TGT_DPCR;
    end else if (address[28:2] == DICR_ADDR[28:2]) begin
      glob_tgt = TGT_DICR;
    end else if (address[28:2] == UNK1_ADDR[28:2]) begin
      glob_tgt = TGT_UNK1;
    end else if (address[28:2] == UNK2_ADDR[28:2]) begin
      glob_tgt = TGT_UNK2;
    end else begin
      glob_tgt = TGT_NONE;
    end

    case (address[3:2])
      2'd0:    chan_tgt = TGT_MADR;
      2'd1:    chan_tgt = TGT_BCR;
      default: chan_tgt = TGT_CHCR;
    endcase

    dec           = '0;
    dec.chan      = address[6:4];
    dec.done_chan = done_channel;
    dec.sub_half  = (access_size == SIZE_HALF);
    dec.sub_sel   = address[1:0];
    dec.wdata     = write_data;

    case (cmd)
      CMD_READ:  dec.op = OP_READ;
      CMD_WRITE: dec.op = OP_WRITE;
      CMD_DONE:  dec.op = OP_DONE;
      default:   dec.op = OP_NONE;
    endcase

    if (access_size == SIZE_WORD) begin
      if (glob_tgt != TGT_NONE && aligned) begin
        dec.target = glob_tgt;
      end else if (chan_ok && aligned) begin
        dec.target = chan_tgt;
      end else begin
        dec.target = TGT_NONE;
      end
    end else if (access_size == SIZE_BYTE || access_size == SIZE_HALF) begin
      // Sub-word accesses to word registers go through the whole word, shifted
      // by the byte offset; only the block control word has true lanes.
      if (glob_tgt != TGT_NONE || (chan_ok && address[3:2] != 2'd1)) begin
        dec.target = (glob_tgt != TGT_NONE) ? glob_tgt : chan_tgt;
        dec.rshift = address[1:0];
        dec.wdata  = write_data << {address[1:0], 3'b000};
      end else if (chan_ok) begin
        dec.target = TGT_BCR_SUB;
      end else begin
        dec.target = TGT_NONE;
      end
    end else begin
      dec.target = TGT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_item <= dec;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dmac_queue.sv
// Short queue of decoded operations between the front end and the register back end.
`timescale 1ns / 1ps
`default_nettype none

module dmac_queue
  import dmac_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire item_t push_item,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output item_t     head
);

  item_t q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dmac_back.sv
// Back end: channel and interrupt registers, executes operations and holds the result.
`timescale 1ns / 1ps
`default_nettype none

module dmac_back
  import dmac_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  empty,
  input  wire item_t head,
  output logic       pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic [31:0] read_data,
  output logic        handled,
  output logic        start_request,
  output logic [2:0]  start_channel,
  output logic        irq_line
);

  logic [23:0] base_address     [CHANNEL_COUNT];
  logic [15:0] block_length     [CHANNEL_COUNT];
  logic [15:0] block_count      [CHANNEL_COUNT];
  logic [14:0] channel_control  [CHANNEL_COUNT];
  logic [3:0]  channel_priority [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] irq_flags;
  logic [CHANNEL_COUNT-1:0] irq_enables;
  logic [7:0]  irq_misc;

  logic [23:0] base_next;
  logic [15:0] length_next;
  logic [15:0] count_next;
  logic [14:0] control_next;
  logic [3:0]  priority_next [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] irq_flags_next;
  logic [CHANNEL_COUNT-1:0] irq_enables_next;
  logic [7:0]  irq_misc_next;

  logic [31:0] word_val;
  logic [31:0] rd_val;
  logic        hit;
  logic        start_val;
  logic        master_now;
  logic        master_next;
  logic [14:0] packed_ctl;
  logic [2:0]  ch;

  function automatic logic [31:0] chcr_unpack(input logic [14:0] c);
    chcr_unpack = {1'b0, c[14:13], c[12], 3'b000, c[11], 1'b0, c[10:8], 1'b0,
                   c[7:5], 5'b00000, c[4:3], 6'b000000, c[2:0]};
  endfunction

  function automatic logic [14:0] chcr_pack(input logic [31:0] d);
    chcr_pack = {d[30:29], d[28], d[24], d[22:20], d[18:16], d[10:9], d[2:0]};
  endfunction

  assign pop = !empty && (!out_valid || !out_stall);
  assign ch  = head.chan;

  assign master_now = irq_misc[6] || (irq_misc[7] && |(irq_flags & irq_enables));

  always_comb begin
    word_val = '0;
    case (head.target)
      TGT_DPCR: begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
          word_val[4*i +: 4] = channel_priority[i];
        end
      end
      TGT_DICR: begin
        word_val[5:0]   = irq_misc[5:0];
        word_val[15]    = irq_misc[6];
        word_val[22:16] = 7'(irq_enables);
        word_val[23]    = irq_misc[7];
        word_val[30:24] = 7'(irq_flags);
        word_val[31]    = master_now;
      end
      TGT_UNK1: word_val = UNK1_VALUE;
      TGT_UNK2: word_val = UNK2_VALUE;
      TGT_MADR: word_val = {8'h00, base_address[ch]};
      TGT_BCR:  word_val = {block_count[ch], block_length[ch]};
      TGT_CHCR: word_val = chcr_unpack(channel_control[ch]);
      default:  word_val = '0;
    endcase
  end

  always_comb begin
    base_next        = base_address[ch];
    length_next      = block_length[ch];
    count_next       = block_count[ch];
    control_next     = channel_control[ch];
    priority_next    = channel_priority;
    irq_flags_next   = irq_flags;
    irq_enables_next = irq_enables;
    irq_misc_next    = irq_misc;
    rd_val           = '0;
    hit              = 1'b0;
    start_val        = 1'b0;

    packed_ctl = chcr_pack(head.wdata);
    if (ch == 3'(TABLE_CHANNEL_ID)) begin
      // The ordering-table channel keeps only enable, trigger and one unknown bit.
      packed_ctl = {packed_ctl[14], 1'b0, packed_ctl[12:11], 9'b0, 1'b1, 1'b0};
    end

    case (head.op)
      OP_READ: begin
        hit = (head.target != TGT_NONE);
        if (head.target == TGT_BCR_SUB) begin
          if (head.sub_half) begin
            rd_val = {16'h0000, head.sub_sel[1] ? block_count[ch] : block_length[ch]};
          end else begin
            case (head.sub_sel)
              2'd0:    rd_val = {24'h0, block_length[ch][7:0]};
              2'd1:    rd_val = {24'h0, block_length[ch][15:8]};
              2'd2:    rd_val = {24'h0, block_count[ch][7:0]};
              default: rd_val = {24'h0, block_count[ch][15:8]};
            endcase
          end
        end else begin
          rd_val = word_val >> {head.rshift, 3'b000};
        end
      end
      OP_WRITE: begin
        hit = (head.target != TGT_NONE);
        case (head.target)
          TGT_DPCR: begin
            for (int i = 0; i < CHANNEL_COUNT; i++) begin
              priority_next[i] = head.wdata[4*i +: 4];
            end
          end
          TGT_DICR: begin
            irq_misc_next    = {head.wdata[23], head.wdata[15], head.wdata[5:0]};
            irq_enables_next = head.wdata[16 +: CHANNEL_COUNT];
            irq_flags_next   = irq_flags & ~head.wdata[24 +: CHANNEL_COUNT];
          end
          TGT_MADR: base_next = head.wdata[23:0];
          TGT_BCR: begin
            length_next = head.wdata[15:0];
            count_next  = head.wdata[31:16];
          end
          TGT_CHCR: begin
            control_next = packed_ctl;
            start_val    = 1'b1;
          end
          TGT_BCR_SUB: begin
            if (head.sub_half) begin
              if (head.sub_sel[1]) begin
                count_next = head.wdata[15:0];
              end else begin
                length_next = head.wdata[15:0];
              end
            end else begin
              case (head.sub_sel)
                2'd0:    length_next[7:0]  = head.wdata[7:0];
                2'd1:    length_next[15:8] = head.wdata[7:0];
                2'd2:    count_next[7:0]   = head.wdata[7:0];
                default: count_next[15:8]  = head.wdata[7:0];
              endcase
            end
          end
          default: begin
          end
        endcase
      end
      OP_DONE: begin
        if (head.done_chan < 3'(CHANNEL_COUNT) && irq_enables[head.done_chan]) begin
          irq_flags_next[head.done_chan] = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (!hit) begin
      rd_val = '0;
    end
    master_next = irq_misc_next[6] ||
                  (irq_misc_next[7] && |(irq_flags_next & irq_enables_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        base_address[i]     <= '0;
        block_length[i]     <= '0;
        block_count[i]      <= '0;
        channel_control[i]  <= '0;
        channel_priority[i] <= '0;
      end
      irq_flags   <= '0;
      irq_enables <= '0;
      irq_misc    <= '0;
    end else if (pop) begin
      if (head.op == OP_WRITE && head.target != TGT_NONE) begin
        base_address[ch]    <= base_next;
        block_length[ch]    <= length_next;
        block_count[ch]     <= count_next;
        channel_control[ch] <= control_next;
      end
      channel_priority <= priority_next;
      irq_flags        <= irq_flags_next;
      irq_enables      <= irq_enables_next;
      irq_misc         <= irq_misc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      read_data     <= rd_val;
      handled       <= hit;
      start_request <= start_val;
      start_channel <= start_val ? ch : 3'd0;
      irq_line      <= master_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dma_controller_register_file.sv
// A transaction passes the front register and the queue; its result is held
// in the output register. Throughput: one transaction per cycle while no side
// stalls; the front register, the two-entry queue and the output register let
// input and output stall independently. Reset (synchronous, active high) clears
// all channel, priority and interrupt registers and empties the pipeline.
// Top level of the DMA controller register file.
`timescale 1ns / 1ps
`default_nettype none

module dma_controller_register_file
  import dmac_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] address,
  input  wire logic [1:0]  access_size,
  input  wire logic [31:0] write_data,
  input  wire logic [2:0]  done_channel,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      read_data,
  output logic             handled,
  output logic             start_request,
  output logic [2:0]       start_channel,
  output logic             irq_line
);

  logic  q_full;
  logic  q_empty;
  logic  push;
  logic  pop;
  item_t push_item;
  item_t head;

  dmac_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .address      (address),
    .access_size  (access_size),
    .write_data   (write_data),
    .done_channel (done_channel),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  dmac_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  dmac_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (q_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .handled       (handled),
    .start_request (start_request),
    .start_channel (start_channel),
    .irq_line      (irq_line)
  );

endmodule

`default_nettype wire
